/* src/sstod_pkg.sv */
`timescale 1ns / 1ps

package sstod_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;

    localparam logic [6:0] ACC_MAX = 7'd127;
    localparam logic [4:0] HOUR_TOP = 5'd23;
    localparam logic [5:0] MIN_TOP  = 6'd59;
    localparam logic [5:0] SEC_TOP  = 6'd59;

    localparam logic [1:0] FIELD_HOUR   = 2'd0;
    localparam logic [1:0] FIELD_MINUTE = 2'd1;
    localparam logic [1:0] FIELD_SECOND = 2'd2;
    localparam logic [1:0] FIELD_TEXT   = 2'd3;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // Multiplies the accumulator by ten, adds the digit and saturates at ACC_MAX.
    function automatic logic [6:0] add_digit(input logic [6:0] acc, input logic [3:0] digit);
        logic [10:0] sum;
        begin
            sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {7'd0, digit};
            if (sum > {4'd0, ACC_MAX})
            begin
                add_digit = ACC_MAX;
            end
            else
            begin
                add_digit = sum[6:0];
            end
        end
    endfunction

endpackage

/* src/serial_settable_time_of_day_clock.sv */
`timescale 1ns / 1ps

// Time-of-day clock set over a serial byte stream.
// The input channel (in_valid, in_stall, action, rx_byte) carries one item per
// transaction: either a received byte (action 0) or a one-second tick (action 1).
// A tick advances the running time. Bytes form lines "hh,mm,ss,text" and a
// newline loads the accumulated values, clamped to 23, 59 and 59.
// The output channel (out_valid, out_stall, hours, minutes, seconds, time_loaded)
// returns exactly one transaction per input transaction, in order, showing the
// time after that item and whether it was a loading newline.
// An accepted item is held in the input register, and its result moves into the
// output register, which raises out_valid, once the output register is free.
// Throughput is one item per cycle while the receiver does not stall, set by the single update stage.
// When the receiver stalls, the result holds in the output register and the
// input register takes one more item if it is empty; once it holds an item,
// in_stall rises until the output is taken.
// Reset clears the time, the line parser and both valid flags.
module serial_settable_time_of_day_clock
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] hours,
    output logic [5:0] minutes,
    output logic [5:0] seconds,
    output logic       time_loaded
);
    import sstod_pkg::*;

    logic       s1_valid_reg;
    logic       s1_action_reg;
    logic [7:0] s1_byte_reg;

    logic [4:0] hour_reg,    hour_next;
    logic [5:0] minute_reg,  minute_next;
    logic [5:0] second_reg,  second_next;
    logic [1:0] field_index_reg, field_index_next;
    logic [6:0] hour_acc_reg,   hour_acc_next;
    logic [6:0] minute_acc_reg, minute_acc_next;
    logic [6:0] second_acc_reg, second_acc_next;
    logic       loaded_next;

    logic       out_valid_reg;
    logic       time_loaded_reg;

    logic       s1_advance;
    logic       in_accept;
    logic [3:0] digit;

    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;
    assign digit      = 4'(s1_byte_reg - CH_ZERO);

    always_comb
    begin
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        field_index_next = field_index_reg;
        hour_acc_next    = hour_acc_reg;
        minute_acc_next  = minute_acc_reg;
        second_acc_next  = second_acc_reg;
        loaded_next      = 1'b0;
        if (s1_action_reg == ACTION_TICK)
        begin
            if (second_reg >= SEC_TOP)
            begin
                second_next = '0;
                if (minute_reg >= MIN_TOP)
                begin
                    minute_next = '0;
                    hour_next   = (hour_reg >= HOUR_TOP) ? 5'd0 : hour_reg + 5'd1;
                end
                else
                begin
                    minute_next = minute_reg + 6'd1;
                end
            end
            else
            begin
                second_next = second_reg + 6'd1;
            end
        end
        else if (s1_byte_reg == CH_NEWLINE)
        begin
            hour_next   = (hour_acc_reg > {2'd0, HOUR_TOP}) ? HOUR_TOP : hour_acc_reg[4:0];
            minute_next = (minute_acc_reg > {1'b0, MIN_TOP}) ? MIN_TOP : minute_acc_reg[5:0];
            second_next = (second_acc_reg > {1'b0, SEC_TOP}) ? SEC_TOP : second_acc_reg[5:0];
            hour_acc_next    = '0;
            minute_acc_next  = '0;
            second_acc_next  = '0;
            field_index_next = FIELD_HOUR;
            loaded_next      = 1'b1;
        end
        else if (s1_byte_reg == CH_COMMA)
        begin
            if (field_index_reg != FIELD_TEXT)
            begin
                field_index_next = field_index_reg + 2'd1;
            end
        end
        else if (s1_byte_reg inside {[CH_ZERO:CH_NINE]})
        begin
            case (field_index_reg)
                FIELD_HOUR:   hour_acc_next   = add_digit(hour_acc_reg, digit);
                FIELD_MINUTE: minute_acc_next = add_digit(minute_acc_reg, digit);
                FIELD_SECOND: second_acc_next = add_digit(second_acc_reg, digit);
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            field_index_reg <= FIELD_HOUR;
            hour_acc_reg    <= '0;
            minute_acc_reg  <= '0;
            second_acc_reg  <= '0;
            time_loaded_reg <= 1'b0;
        end
        else
        begin
            if (in_accept || s1_advance)
            begin
                s1_valid_reg <= in_accept;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    hour_reg        <= hour_next;
                    minute_reg      <= minute_next;
                    second_reg      <= second_next;
                    field_index_reg <= field_index_next;
                    hour_acc_reg    <= hour_acc_next;
                    minute_acc_reg  <= minute_acc_next;
                    second_acc_reg  <= second_acc_next;
                    time_loaded_reg <= loaded_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_byte_reg   <= rx_byte;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hours       = hour_reg;
    assign minutes     = minute_reg;
    assign seconds     = second_reg;
    assign time_loaded = time_loaded_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        hour_reg <= HOUR_TOP && minute_reg <= MIN_TOP && second_reg <= SEC_TOP)
        else $error("Running time is out of range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && time_loaded_reg |->
            field_index_reg == FIELD_HOUR && hour_acc_reg == '0
            && minute_acc_reg == '0 && second_acc_reg == '0)
        else $error("Line parser was not cleared by a loading newline.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("Input stalled while the pipeline has room.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(hour_reg) && $stable(field_index_reg)
            && $stable(hour_acc_reg))
        else $error("Clock state changed while a result was held.");

endmodule
